>>> rtl/nvt_pkg.sv
// Shared constants, types and codes of the neighbour table.
package nvt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ID_W        = 8;
   localparam int MASK_W      = 16;
   localparam int VER_W       = 8;
   localparam int TIMER_W     = 8;
   localparam int COUNT_OUT_W = 5;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_INIT = 1'd1;
   localparam logic [TIMER_W-1:0]   TIMER_INIT_RESET = 8'd200;

   typedef enum logic [1:0] {
      CMD_DROP,
      CMD_ANN,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ID_W-1:0]     id;
      logic [MASK_W-1:0]   mask;
      logic [VER_W-1:0]    ver;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [MASK_W-1:0]   mask;
      logic [VER_W-1:0]    ver;
      logic [TIMER_W-1:0]  timer;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> rtl/nvt_req_if.sv
// Announcement and tick request channel.
interface nvt_req_if import nvt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ID_W-1:0]   node_id;
   logic [MASK_W-1:0] group_mask;
   logic [VER_W-1:0]  version;
   logic              check_ok;

   modport source (output valid, mode, node_id, group_mask, version, check_ok, input ready);
   modport sink   (input valid, mode, node_id, group_mask, version, check_ok, output ready);
endinterface

>>> rtl/nvt_rsp_if.sv
// Forwarding response channel.
interface nvt_rsp_if import nvt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   forward;
   logic [ID_W-1:0]        fwd_id;
   logic [MASK_W-1:0]      fwd_mask;
   logic [VER_W-1:0]       fwd_version;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, forward, fwd_id, fwd_mask, fwd_version, entry_count,
                   input ready);
   modport sink   (input valid, forward, fwd_id, fwd_mask, fwd_version, entry_count,
                   output ready);
endinterface

>>> rtl/nvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/nvt_front.sv
// Request intake: classify each transfer and queue it for the table sequencer.
module nvt_front import nvt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   nvt_req_if.sink         req_if,
   input  logic [ID_W-1:0] own_id,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output cmd_type         cmd
);
   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    cmd_in;
   logic       push, pop;

   always_comb begin
      cmd_in.id   = req_if.node_id;
      cmd_in.mask = req_if.group_mask;
      cmd_in.ver  = req_if.version;
      if (req_if.mode) begin
         cmd_in.kind = CMD_TICK;
      end else if (req_if.check_ok && (req_if.node_id != own_id)) begin
         cmd_in.kind = CMD_ANN;
      end else begin
         cmd_in.kind = CMD_DROP;
      end
   end

   assign req_if.ready = (fill_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign cmd_valid    = (fill_ff != 2'd0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end
endmodule

>>> rtl/nvt_back.sv
// Table sequencer: lookup, insert, aging walk and the response register.
module nvt_back import nvt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cmd_type            cmd,
   input  logic [TIMER_W-1:0] timer_init,
   nvt_rsp_if.source          rsp_if
);
   localparam logic [1:0] S_IDLE     = 2'd0;
   localparam logic [1:0] S_LOOK     = 2'd1;
   localparam logic [1:0] S_AGE_CHK  = 2'd2;
   localparam logic [1:0] S_AGE_MOVE = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   cmd_type                cur_ff, cur_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   fwd_ff, fwd_in;
   logic [ID_W-1:0]        fwd_id_ff, fwd_id_in;
   logic [MASK_W-1:0]      fwd_mask_ff, fwd_mask_in;
   logic [VER_W-1:0]       fwd_ver_ff, fwd_ver_in;
   logic [COUNT_OUT_W-1:0] cnt_out_ff, cnt_out_in;

   logic             out_free;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;
   logic             finish, fwd_set, decide, present;
   logic [IDX_W-1:0] pos;
   logic [CNT_W-1:0] idx_next_c, last_c;
   cmd_type          act;

   nvt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign idx_next_c = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_c     = count_ff - CNT_W'(1);
   assign act        = (state_ff == S_IDLE) ? cmd : cur_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      rd_addr   = idx_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data;
      finish    = 1'b0;
      fwd_set   = 1'b0;
      cmd_ready = 1'b0;
      decide    = 1'b0;
      present   = 1'b0;
      pos       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               cur_in    = cmd;
               idx_in    = '0;
               rd_addr   = '0;
               case (cmd.kind)
                  CMD_ANN: begin
                     if (count_ff == '0) begin
                        decide = 1'b1;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  CMD_TICK: begin
                     if (count_ff == '0) begin
                        finish = 1'b1;
                     end else begin
                        state_in = S_AGE_CHK;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_LOOK: begin
            if (rd_data.id == cur_ff.id) begin
               decide  = 1'b1;
               present = 1'b1;
            end else if (idx_next_c == count_ff) begin
               decide = 1'b1;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         S_AGE_CHK: begin
            if (rd_data.timer != '0) begin
               wr_en         = 1'b1;
               wr_data.timer = rd_data.timer - TIMER_W'(1);
               if (idx_next_c >= count_ff) begin
                  finish = 1'b1;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end else if (CNT_W'(idx_ff) == last_c) begin
               count_in = last_c;
               finish   = 1'b1;
            end else begin
               rd_addr  = IDX_W'(last_c);
               state_in = S_AGE_MOVE;
            end
         end
         S_AGE_MOVE: begin
            wr_en    = 1'b1;
            count_in = last_c;
            if (idx_next_c >= last_c) begin
               finish = 1'b1;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               rd_addr  = idx_ff + IDX_W'(1);
               state_in = S_AGE_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (decide) begin
         finish = 1'b1;
         if (!present || (rd_data.ver < act.ver)) begin
            fwd_set       = 1'b1;
            wr_data.id    = act.id;
            wr_data.mask  = act.mask;
            wr_data.ver   = act.ver;
            wr_data.timer = timer_init;
            if (present) begin
               wr_en   = 1'b1;
               wr_addr = pos;
            end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
      end

      if (finish) begin
         state_in = S_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      fwd_in       = fwd_ff;
      fwd_id_in    = fwd_id_ff;
      fwd_mask_in  = fwd_mask_ff;
      fwd_ver_in   = fwd_ver_ff;
      cnt_out_in   = cnt_out_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         fwd_in       = fwd_set;
         fwd_id_in    = fwd_set ? act.id : '0;
         fwd_mask_in  = fwd_set ? act.mask : '0;
         fwd_ver_in   = fwd_set ? act.ver : '0;
         cnt_out_in   = COUNT_OUT_W'(count_in);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      fwd_ff      <= fwd_in;
      fwd_id_ff   <= fwd_id_in;
      fwd_mask_ff <= fwd_mask_in;
      fwd_ver_ff  <= fwd_ver_in;
      cnt_out_ff  <= cnt_out_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.forward     = fwd_ff;
   assign rsp_if.fwd_id      = fwd_id_ff;
   assign rsp_if.fwd_mask    = fwd_mask_ff;
   assign rsp_if.fwd_version = fwd_ver_ff;
   assign rsp_if.entry_count = cnt_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_walk_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending during a table walk");

   a_grow_on_lookup: assert property (@(posedge clock) disable iff (reset)
      (count_in > count_ff) |-> (decide && !present && (count_in == count_ff + CNT_W'(1))))
      else $error("table grew outside an insert");

   a_drop_zeroes: assert property (@(posedge clock) disable iff (reset)
      (finish && !fwd_set) |=> (fwd_id_ff == '0 && fwd_mask_ff == '0 && fwd_ver_ff == '0))
      else $error("forward fields not cleared");
endmodule

>>> rtl/versioned_neighbor_table_with_aging_core.sv
// Versioned neighbour table with aging: top level.
//
// req_if carries one transfer per announcement (mode 0) or aging tick (mode 1);
// rsp_if returns exactly one transfer per request, in order, with the forward
// decision and the entry count after the step. csr_we/csr_index/csr_wdata
// write own_id (index 0) and timer_init (index 1); the user must write them
// only while the block is idle; the block itself does not enforce this.
// Requests are classified on entry and wait in a two-deep queue; the
// sequencer then walks the table RAM one entry per cycle through its single
// read port, with a second read for each expired entry. Rejected requests and
// requests meeting an empty table skip the walk; an announcement or aging tick
// walks at most the occupied entries. One request is worked on at a time; the
// next one starts once its response register is free.
// Reset empties the table and the queue, sets own_id to 0 and timer_init to
// 200. A stalled rsp_if holds its transfer; the queue keeps accepting until
// full, then drops req_if.ready.
module versioned_neighbor_table_with_aging_core import nvt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   nvt_req_if.sink               req_if,
   nvt_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [ID_W-1:0]    own_id_ff;
   logic [TIMER_W-1:0] timer_init_ff;
   logic               cmd_valid, cmd_ready;
   cmd_type            cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= '0;
         timer_init_ff <= TIMER_INIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID:     own_id_ff     <= ID_W'(csr_wdata);
            CSR_TIMER_INIT: timer_init_ff <= TIMER_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   nvt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .own_id    (own_id_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   nvt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .timer_init (timer_init_ff),
      .rsp_if     (rsp_if)
   );
endmodule
